[design/maa_pkg.sv]
// Shared types, constants and helpers of the multichannel average accumulator.
`timescale 1ns / 1ps

package maa_pkg;

    // Fixed field widths.
    localparam int CH_BITS     = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 32;
    localparam int COUNT_BITS  = 16;
    localparam int NCH_BITS    = 5;

    // Channel addresses the channel field can reach.
    localparam int ADDR_LIMIT = 16;

    // Configuration port.
    localparam int REG_INDEX_BITS = 1;
    localparam int REG_DATA_BITS  = 5;
    localparam logic [REG_INDEX_BITS-1:0] REG_CHAN_COUNT   = 1'b0;
    localparam logic [REG_INDEX_BITS-1:0] REG_TRACK_MINMAX = 1'b1;
    localparam logic [NCH_BITS-1:0]       CHAN_COUNT_RESET   = 5'd16;
    localparam logic                      TRACK_MINMAX_RESET = 1'b0;

    // Request code carried in the func field.
    localparam logic FUNC_READ = 1'b1;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        OP_ADD,
        OP_READ
    } op_t;

    // One classified command as it travels from front to back.
    typedef struct packed
    {
        op_t                    op;
        logic [CH_BITS-1:0]     channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   sweep_end;
        logic                   track;
        logic [NCH_BITS-1:0]    n_ch;
    } cmd_t;

    // Channel count in force: zero acts as one, large values clamp to the limit.
    function automatic logic [NCH_BITS-1:0] eff_channels(
        input logic [NCH_BITS-1:0] num,
        input logic [NCH_BITS-1:0] lim
    );
        logic [NCH_BITS-1:0] n;
        n = num;
        if (n == '0)
        begin
            n = NCH_BITS'(1);
        end
        if (n > lim)
        begin
            n = lim;
        end
        return n;
    endfunction

endpackage

[design/maa_in_if.sv]
// Input channel: sample and read-out requests.
`timescale 1ns / 1ps

interface maa_in_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [maa_pkg::CH_BITS-1:0]      channel;
    logic [maa_pkg::SAMPLE_BITS-1:0]  sample;

    modport source (output valid, output func, output channel, output sample, input ready);
    modport sink (input valid, input func, input channel, input sample, output ready);
endinterface

[design/maa_out_if.sv]
// Output channel: one average per channel of a read-out.
`timescale 1ns / 1ps

interface maa_out_if;
    logic                             valid;
    logic                             ready;
    logic [maa_pkg::CH_BITS-1:0]      out_channel;
    logic [maa_pkg::SAMPLE_BITS-1:0]  average;
    logic                             last;
    logic                             no_samples;
    logic [maa_pkg::SAMPLE_BITS-1:0]  min_value;
    logic [maa_pkg::SAMPLE_BITS-1:0]  max_value;

    modport source (
        output valid, output out_channel, output average, output last,
        output no_samples, output min_value, output max_value, input ready
    );
    modport sink (
        input valid, input out_channel, input average, input last,
        input no_samples, input min_value, input max_value, output ready
    );
endinterface

[design/maa_front.sv]
// Front end: configuration registers, input acceptance and command classification.
`timescale 1ns / 1ps

module maa_front #(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    maa_in_if.sink                               item,
    input  logic                                 wr_en,
    input  logic [maa_pkg::REG_INDEX_BITS-1:0]   wr_index,
    input  logic [maa_pkg::REG_DATA_BITS-1:0]    wr_data,
    input  logic                                 queue_full,
    output logic                                 push,
    output maa_pkg::cmd_t                        push_cmd
);

    localparam int CH_LIMIT = (MAX_CHANNELS < maa_pkg::ADDR_LIMIT) ?
                              MAX_CHANNELS : maa_pkg::ADDR_LIMIT;
    localparam int MASK_INT = (1 << SAMPLE_WIDTH) - 1;

    logic [maa_pkg::NCH_BITS-1:0]    chan_count_reg;
    logic                            track_minmax_reg;
    logic [maa_pkg::NCH_BITS-1:0]    n_eff;
    logic [maa_pkg::SAMPLE_BITS-1:0] sample_mask;
    logic                            is_read;
    logic                            in_range;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg   <= maa_pkg::CHAN_COUNT_RESET;
            track_minmax_reg <= maa_pkg::TRACK_MINMAX_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                maa_pkg::REG_CHAN_COUNT:   chan_count_reg   <= wr_data[maa_pkg::NCH_BITS-1:0];
                maa_pkg::REG_TRACK_MINMAX: track_minmax_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // Classify the incoming beat; samples beyond the sweep are taken and dropped.
    always_comb
    begin
        n_eff       = maa_pkg::eff_channels(chan_count_reg, CH_LIMIT[maa_pkg::NCH_BITS-1:0]);
        sample_mask = MASK_INT[maa_pkg::SAMPLE_BITS-1:0];
        is_read     = (item.func == maa_pkg::FUNC_READ);
        in_range    = ({1'b0, item.channel} < n_eff);

        item.ready = !queue_full;
        push       = item.valid && !queue_full && (is_read || in_range);

        push_cmd.op        = is_read ? maa_pkg::OP_READ : maa_pkg::OP_ADD;
        push_cmd.channel   = item.channel;
        push_cmd.sample    = item.sample & sample_mask;
        push_cmd.sweep_end = ({1'b0, item.channel} == (n_eff - maa_pkg::NCH_BITS'(1)));
        push_cmd.track     = track_minmax_reg;
        push_cmd.n_ch      = n_eff;
    end

endmodule

[design/maa_queue.sv]
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module maa_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  maa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output maa_pkg::cmd_t head
);

    localparam int PTR_BITS  = (maa_pkg::QUEUE_DEPTH > 1) ? $clog2(maa_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(maa_pkg::QUEUE_DEPTH + 1);

    maa_pkg::cmd_t        slot_reg [maa_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [FILL_BITS-1:0] fill_reg;
    logic [FILL_BITS-1:0] fill_next;

    assign full  = (fill_reg == FILL_BITS'(maa_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Advance a pointer, wrapping at the queue depth.
    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(maa_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_BITS'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !full)
        begin
            fill_next = fill_next + FILL_BITS'(1);
        end
        if (pop && !empty)
        begin
            fill_next = fill_next - FILL_BITS'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            fill_reg <= fill_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/maa_div.sv]
// Radix-2 restoring divider: channel sum by sweep count, one quotient bit a cycle.
`timescale 1ns / 1ps

module maa_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [maa_pkg::SUM_BITS-1:0]     dividend,
    input  logic [maa_pkg::COUNT_BITS-1:0]   divisor,
    output logic                             done,
    output logic [maa_pkg::SAMPLE_BITS-1:0]  quotient
);

    localparam int STEP_BITS = $clog2(maa_pkg::SUM_BITS + 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [STEP_BITS-1:0]             step_reg;
    logic [maa_pkg::COUNT_BITS-1:0]   rem_reg;
    logic [maa_pkg::SUM_BITS-1:0]     quo_reg;
    logic [maa_pkg::COUNT_BITS-1:0]   divisor_reg;
    logic [maa_pkg::COUNT_BITS:0]     trial;
    logic [maa_pkg::COUNT_BITS:0]     rem_next;
    logic                             fits;

    // One shift-and-subtract step.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[maa_pkg::SUM_BITS-1]};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? (trial - {1'b0, divisor_reg}) : trial;
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(maa_pkg::SUM_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_BITS'(1);
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[maa_pkg::COUNT_BITS-1:0];
            quo_reg <= {quo_reg[maa_pkg::SUM_BITS-2:0], fits};
        end
    end

    // A quotient that does not fit the result field saturates.
    assign done     = done_reg;
    assign quotient = (|quo_reg[maa_pkg::SUM_BITS-1:maa_pkg::SAMPLE_BITS]) ?
                      '1 : quo_reg[maa_pkg::SAMPLE_BITS-1:0];

endmodule

[design/maa_back.sv]
// Back end: channel sums, sweep count, min/max tracking and the read-out sequencer.
`timescale 1ns / 1ps

module maa_back #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  maa_pkg::cmd_t                    head,
    output logic                             pop,
    output logic                             div_start,
    output logic [maa_pkg::SUM_BITS-1:0]     div_dividend,
    output logic [maa_pkg::COUNT_BITS-1:0]   div_divisor,
    input  logic                             div_done,
    input  logic [maa_pkg::SAMPLE_BITS-1:0]  div_quotient,
    maa_out_if.source                        result
);

    localparam int SUM_DEPTH = (MAX_CHANNELS < maa_pkg::ADDR_LIMIT) ?
                               MAX_CHANNELS : maa_pkg::ADDR_LIMIT;
    localparam int IDX_W     = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                           state_reg;
    logic [maa_pkg::SUM_BITS-1:0]     sum_reg [SUM_DEPTH];
    logic [SUM_DEPTH-1:0]             sum_valid_reg;
    logic [maa_pkg::COUNT_BITS-1:0]   count_reg;
    logic [maa_pkg::SAMPLE_BITS-1:0]  min_reg;
    logic [maa_pkg::SAMPLE_BITS-1:0]  max_reg;
    logic [maa_pkg::NCH_BITS-1:0]     n_reg;
    logic [maa_pkg::CH_BITS-1:0]      idx_reg;
    logic [maa_pkg::SAMPLE_BITS-1:0]  avg_reg;
    logic                             none_reg;

    logic                             result_valid_reg;
    logic [maa_pkg::CH_BITS-1:0]      out_channel_reg;
    logic [maa_pkg::SAMPLE_BITS-1:0]  average_reg;
    logic                             last_reg;
    logic                             no_samples_reg;
    logic [maa_pkg::SAMPLE_BITS-1:0]  min_value_reg;
    logic [maa_pkg::SAMPLE_BITS-1:0]  max_value_reg;

    logic [IDX_W-1:0]                 rd_idx;
    logic [maa_pkg::SUM_BITS-1:0]     rd_sum;
    logic [maa_pkg::SUM_BITS:0]       sum_add;
    logic [maa_pkg::SUM_BITS-1:0]     sum_new;
    logic                             do_add;
    logic                             last_ch;
    logic                             out_free;
    logic                             emit;

    // Single read port on the sums: the queued sample in idle, the walk index otherwise.
    always_comb
    begin
        rd_idx   = (state_reg == ST_IDLE) ? head.channel[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        rd_sum   = sum_valid_reg[rd_idx] ? sum_reg[rd_idx] : '0;
        sum_add  = {1'b0, rd_sum} + (maa_pkg::SUM_BITS + 1)'(head.sample);
        sum_new  = sum_add[maa_pkg::SUM_BITS] ? '1 : sum_add[maa_pkg::SUM_BITS-1:0];
        pop      = (state_reg == ST_IDLE) && !empty;
        do_add   = pop && (head.op == maa_pkg::OP_ADD);
        last_ch  = ({1'b0, idx_reg} == (n_reg - maa_pkg::NCH_BITS'(1)));
        out_free = !result_valid_reg || result.ready;
        emit     = (state_reg == ST_EMIT) && out_free;

        div_start    = (state_reg == ST_START) && (count_reg != '0);
        div_dividend = rd_sum;
        div_divisor  = count_reg;
    end

    // Sequencer, accumulator state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sum_valid_reg    <= '0;
            count_reg        <= '0;
            min_reg          <= '0;
            max_reg          <= '0;
            n_reg            <= '0;
            idx_reg          <= '0;
            avg_reg          <= '0;
            none_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            out_channel_reg  <= '0;
            average_reg      <= '0;
            last_reg         <= 1'b0;
            no_samples_reg   <= 1'b0;
            min_value_reg    <= '0;
            max_value_reg    <= '0;
        end
        else
        begin
            // The output register fills on an emit and empties when its beat is taken.
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (do_add)
                    begin
                        sum_valid_reg[rd_idx] <= 1'b1;
                        if (head.sweep_end)
                        begin
                            if (count_reg != '1)
                            begin
                                count_reg <= count_reg + maa_pkg::COUNT_BITS'(1);
                            end
                            if (head.track)
                            begin
                                if ((min_reg == '0) || (min_reg > head.sample))
                                begin
                                    min_reg <= head.sample;
                                end
                                if ((max_reg == '0) || (max_reg < head.sample))
                                begin
                                    max_reg <= head.sample;
                                end
                            end
                        end
                    end
                    else if (pop)
                    begin
                        n_reg     <= head.n_ch;
                        idx_reg   <= '0;
                        state_reg <= ST_START;
                    end
                end

                ST_START:
                begin
                    if (count_reg == '0)
                    begin
                        avg_reg   <= '0;
                        none_reg  <= 1'b1;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        none_reg  <= 1'b0;
                        state_reg <= ST_WAIT;
                    end
                end

                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_quotient;
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_channel_reg  <= idx_reg;
                        average_reg      <= avg_reg;
                        last_reg         <= last_ch;
                        no_samples_reg   <= none_reg;
                        min_value_reg    <= min_reg;
                        max_value_reg    <= max_reg;
                        if (last_ch)
                        begin
                            // Read-out done: every sum, the count and min/max start over.
                            sum_valid_reg <= '0;
                            count_reg     <= '0;
                            min_reg       <= '0;
                            max_reg       <= '0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + maa_pkg::CH_BITS'(1);
                            state_reg <= ST_START;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sum storage, written by the saturating add.
    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            sum_reg[rd_idx] <= sum_new;
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.out_channel = out_channel_reg;
    assign result.average     = average_reg;
    assign result.last        = last_reg;
    assign result.no_samples  = no_samples_reg;
    assign result.min_value   = min_value_reg;
    assign result.max_value   = max_value_reg;

endmodule

[design/multichannel_adc_average_accumulator_core.sv]
// Top level of the multichannel average accumulator.
`timescale 1ns / 1ps
// The item channel takes beats tagged with func: an add beat adds sample into the
// sum of its channel, a read beat asks for one average per configured channel.
// Add beats for a channel at or beyond the channel count are taken and dropped.
// The result channel carries the averages in channel order, last set on the final one,
// together with the min/max of the last channel and a no_samples flag.
// Configuration is written through wr_en/wr_index/wr_data; the user must do so only while
// the block is idle, as the block itself does not enforce it.
// Throughput: one add beat per cycle while the command queue has room.
// A read-out walks the channels in order; per channel it starts the 32-step restoring
// divider (one quotient bit a cycle) if the sweep count is non-zero, then emits the average.
// Beats behind a read-out wait in the two-entry queue; item.ready drops once it is full.
// A stalled receiver holds the result register and pauses the channel walk.
// Reset clears all sums, the sweep count, min/max, the queue and the output valid,
// and restores the channel count to 16 and min/max tracking to off; no clearing pass follows.

module multichannel_adc_average_accumulator_core #(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    maa_in_if.sink                               item,
    maa_out_if.source                            result,
    input  logic                                 wr_en,
    input  logic [maa_pkg::REG_INDEX_BITS-1:0]   wr_index,
    input  logic [maa_pkg::REG_DATA_BITS-1:0]    wr_data
);

    logic                             push;
    maa_pkg::cmd_t                    push_cmd;
    logic                             queue_full;
    logic                             queue_empty;
    logic                             pop;
    maa_pkg::cmd_t                    head;
    logic                             div_start;
    logic [maa_pkg::SUM_BITS-1:0]     div_dividend;
    logic [maa_pkg::COUNT_BITS-1:0]   div_divisor;
    logic                             div_done;
    logic [maa_pkg::SAMPLE_BITS-1:0]  div_quotient;

    // Accept and classify.
    maa_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue.
    maa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    // Accumulate and read out.
    maa_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .head         (head),
        .pop          (pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .result       (result)
    );

    // Shared divider.
    maa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule

[design/maa_checker.sv]
// Port-level checks of the multichannel average accumulator, bound to the top level.
`timescale 1ns / 1ps

module maa_port_assert (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [maa_pkg::CH_BITS-1:0]      result_out_channel,
    input logic [maa_pkg::SAMPLE_BITS-1:0]  result_average,
    input logic                             result_no_samples,
    input logic [maa_pkg::SAMPLE_BITS-1:0]  result_min_value,
    input logic [maa_pkg::SAMPLE_BITS-1:0]  result_max_value
);

    // A stalled result beat holds.
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_average) && $stable(result_out_channel)
    ) else $error("result beat changed while stalled");

    // An empty sweep count forces a zero average.
    a_no_samples_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_no_samples |-> (result_average == '0)
    ) else $error("average not zero with no samples");

    // A set minimum never exceeds the maximum.
    a_min_below_max: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && (result_min_value != '0) |-> (result_min_value <= result_max_value)
    ) else $error("minimum above maximum");

    // No result is offered right out of reset.
    a_quiet_after_reset: assert property (
        @(posedge clk)
        $rose(rst_n) |-> !result_valid
    ) else $error("result valid right after reset");

endmodule

bind multichannel_adc_average_accumulator_core maa_port_assert u_maa_port_assert (
    .clk                (clk),
    .rst_n              (rst_n),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_out_channel (result.out_channel),
    .result_average     (result.average),
    .result_no_samples  (result.no_samples),
    .result_min_value   (result.min_value),
    .result_max_value   (result.max_value)
);

[sim/maa_checker.sv]
// Checker that predicts and compares the averages of the accumulator core.
`timescale 1ns / 1ps

module maa_checker #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    maa_in_if                                  item,
    maa_out_if                                 result,
    input  logic                               wr_en,
    input  logic [maa_pkg::REG_INDEX_BITS-1:0] wr_index,
    input  logic [maa_pkg::REG_DATA_BITS-1:0]  wr_data,
    output int                                 pending,
    output int                                 fail_count
);

    // Highest channel count a sweep can have.
    localparam int CH_LIMIT = (MAX_CHANNELS < maa_pkg::ADDR_LIMIT) ?
                              MAX_CHANNELS : maa_pkg::ADDR_LIMIT;

    // One predicted average beat.
    typedef struct packed
    {
        logic [maa_pkg::CH_BITS-1:0]     out_channel;
        logic [maa_pkg::SAMPLE_BITS-1:0] average;
        logic                            last;
        logic                            no_samples;
        logic [maa_pkg::SAMPLE_BITS-1:0] min_value;
        logic [maa_pkg::SAMPLE_BITS-1:0] max_value;
    } average_t;

    // Shadow copy of the accumulator state and its registers.
    logic [maa_pkg::SUM_BITS-1:0]    chan_sum [maa_pkg::ADDR_LIMIT];
    logic [maa_pkg::COUNT_BITS-1:0]  sweeps;
    logic [maa_pkg::SAMPLE_BITS-1:0] low_mark;
    logic [maa_pkg::SAMPLE_BITS-1:0] high_mark;
    logic [maa_pkg::NCH_BITS-1:0]    nch_cfg;
    logic                            track_cfg;

    average_t averages_due[$];
    int       mismatches = 0;

    assign fail_count = mismatches;

    // Channel count in force: zero acts as one, large values clamp.
    function automatic int channels_in_force();
        int n;
        n = nch_cfg;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > CH_LIMIT)
        begin
            n = CH_LIMIT;
        end
        return n;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic clear_sums();
        foreach (chan_sum[i])
        begin
            chan_sum[i] = '0;
        end
        sweeps    = '0;
        low_mark  = '0;
        high_mark = '0;
    endtask

    // Add one sample; the last channel of the sweep closes it and feeds min/max.
    task automatic accumulate(
        input logic [maa_pkg::CH_BITS-1:0]     ch,
        input logic [maa_pkg::SAMPLE_BITS-1:0] smp
    );
        int                         n;
        logic [maa_pkg::SUM_BITS:0] wide;
        n = channels_in_force();
        if (ch >= n)
        begin
            return;
        end
        wide = {1'b0, chan_sum[ch]} + smp;
        chan_sum[ch] = wide[maa_pkg::SUM_BITS] ? '1 : wide[maa_pkg::SUM_BITS-1:0];
        if (ch == n - 1)
        begin
            if (sweeps != '1)
            begin
                sweeps++;
            end
            // A stored zero counts as unset, so a zero sample leaves it unset.
            if (track_cfg)
            begin
                if (low_mark == '0 || low_mark > smp)
                begin
                    low_mark = smp;
                end
                if (high_mark == '0 || high_mark < smp)
                begin
                    high_mark = smp;
                end
            end
        end
    endtask

    // A read-out queues one average per channel, then clears everything.
    task automatic dump_averages();
        int                           n;
        average_t                     due;
        logic [maa_pkg::SUM_BITS-1:0] quotient;
        n = channels_in_force();
        for (int i = 0; i < n; i++)
        begin
            due.out_channel = maa_pkg::CH_BITS'(i);
            due.no_samples  = (sweeps == '0);
            quotient        = '0;
            if (!due.no_samples)
            begin
                quotient = chan_sum[i] / sweeps;
            end
            due.average   = (quotient > 32'hFFFF) ? '1 : quotient[maa_pkg::SAMPLE_BITS-1:0];
            due.last      = (i == n - 1);
            due.min_value = low_mark;
            due.max_value = high_mark;
            averages_due.push_back(due);
        end
        clear_sums();
    endtask

    // Compare an accepted average beat with the oldest prediction.
    task automatic check_average();
        average_t due;
        if (averages_due.size() == 0)
        begin
            report($sformatf("average beat for channel %0d with nothing expected",
                             result.out_channel));
            return;
        end
        due = averages_due.pop_front();
        if (result.out_channel !== due.out_channel)
        begin
            report($sformatf("out_channel: got %0d, expected %0d",
                             result.out_channel, due.out_channel));
        end
        if (result.average !== due.average)
        begin
            report($sformatf("average of channel %0d: got 0x%0h, expected 0x%0h",
                             due.out_channel, result.average, due.average));
        end
        if (result.last !== due.last)
        begin
            report($sformatf("last of channel %0d: got %0b, expected %0b",
                             due.out_channel, result.last, due.last));
        end
        if (result.no_samples !== due.no_samples)
        begin
            report($sformatf("no_samples of channel %0d: got %0b, expected %0b",
                             due.out_channel, result.no_samples, due.no_samples));
        end
        if (result.min_value !== due.min_value)
        begin
            report($sformatf("min_value of channel %0d: got 0x%0h, expected 0x%0h",
                             due.out_channel, result.min_value, due.min_value));
        end
        if (result.max_value !== due.max_value)
        begin
            report($sformatf("max_value of channel %0d: got 0x%0h, expected 0x%0h",
                             due.out_channel, result.max_value, due.max_value));
        end
    endtask

    // Follow register writes, input beats and average beats edge by edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sums();
            nch_cfg   = maa_pkg::CHAN_COUNT_RESET;
            track_cfg = maa_pkg::TRACK_MINMAX_RESET;
            averages_due.delete();
            pending <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    maa_pkg::REG_CHAN_COUNT:   nch_cfg   = wr_data[maa_pkg::NCH_BITS-1:0];
                    maa_pkg::REG_TRACK_MINMAX: track_cfg = wr_data[0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (maa_pkg::op_t'(item.func) == maa_pkg::OP_READ)
                begin
                    dump_averages();
                end
                else
                begin
                    accumulate(item.channel, item.sample);
                end
            end
            if (result.valid && result.ready)
            begin
                check_average();
            end
            pending <= averages_due.size();
        end
    end

endmodule

[sim/tb_multichannel_adc_average_accumulator_core.sv]
// Testbench top: stimulus, register writes and verdict for the accumulator core.
`timescale 1ns / 1ps

module tb_multichannel_adc_average_accumulator_core;

    // Slowest run: some 130 beats, each read-out up to 16 averages, with receiver stalls,
    // stays below CYCLE_LIMIT.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 85;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               wr_en;
    logic [maa_pkg::REG_INDEX_BITS-1:0] wr_index;
    logic [maa_pkg::REG_DATA_BITS-1:0]  wr_data;
    int                                 cycles = 0;
    int                                 waiting;
    int                                 fail_count;
    bit                                 src_calm = 1'b0;
    bit                                 sink_calm = 1'b0;
    int                                 sink_hold = 0;

    maa_in_if  item_ch();
    maa_out_if res_ch();

    multichannel_adc_average_accumulator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    maa_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .pending    (waiting),
        .fail_count (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // Run guard.
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: holds ready for random stretches, mostly short, a few long stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
        end
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (sink_calm || r < 65)
            begin
                res_ch.ready <= 1'b1;
                sink_hold = $urandom_range(0, 4);
            end
            else if (r < 95)
            begin
                res_ch.ready <= 1'b0;
                sink_hold = $urandom_range(0, 3);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                sink_hold = $urandom_range(10, 50);
            end
        end
    end

    function automatic int source_gap();
        int r;
        if (src_calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Samples lean toward the ends of the range.
    function automatic logic [maa_pkg::SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        if (r == 2)
        begin
            return maa_pkg::SAMPLE_BITS'($urandom_range(1, 15));
        end
        return maa_pkg::SAMPLE_BITS'($urandom);
    endfunction

    // Sweep length for a written channel count.
    function automatic int sweep_len(input int raw);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > maa_pkg::ADDR_LIMIT) ? maa_pkg::ADDR_LIMIT : raw;
    endfunction

    // Present one beat after a random gap and hold it until it is taken.
    task automatic send_beat(
        input maa_pkg::op_t                    op,
        input logic [maa_pkg::CH_BITS-1:0]     ch,
        input logic [maa_pkg::SAMPLE_BITS-1:0] smp
    );
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= op;
        item_ch.channel <= ch;
        item_ch.sample  <= smp;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Wait for every expected average, then let queued adds drain.
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [maa_pkg::NCH_BITS-1:0] nch, input logic trk);
        wr_en    <= 1'b1;
        wr_index <= maa_pkg::REG_CHAN_COUNT;
        wr_data  <= maa_pkg::REG_DATA_BITS'(nch);
        @(posedge clk);
        wr_index <= maa_pkg::REG_TRACK_MINMAX;
        wr_data  <= maa_pkg::REG_DATA_BITS'(trk);
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    initial
    begin
        int                          n;
        int                          nch_raw;
        int                          reads;
        int                          sweeps;
        int                          random_items;
        logic                        trk;
        logic [maa_pkg::CH_BITS-1:0] ch;
        bit                          broken;

        random_items = 0;
        item_ch.valid   <= 1'b0;
        item_ch.func    <= maa_pkg::OP_ADD;
        item_ch.channel <= '0;
        item_ch.sample  <= '0;
        wr_en    <= 1'b0;
        wr_index <= maa_pkg::REG_CHAN_COUNT;
        wr_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read-out under reset settings with nothing accumulated.
        send_beat(maa_pkg::OP_READ, 4'hF, 16'hFFFF);
        settle();

        // Two channels with tracking: zero sample, average overflow, beats beyond the sweep.
        set_config(maa_pkg::NCH_BITS'(2), 1'b1);
        send_beat(maa_pkg::OP_ADD, 4'd1, 16'h0000);
        send_beat(maa_pkg::OP_ADD, 4'd0, 16'hFFFF);
        send_beat(maa_pkg::OP_ADD, 4'd0, 16'hFFFF);
        send_beat(maa_pkg::OP_ADD, 4'd0, 16'hFFFF);
        send_beat(maa_pkg::OP_ADD, 4'd1, 16'h0001);
        send_beat(maa_pkg::OP_ADD, 4'd3, 16'h1234);
        send_beat(maa_pkg::OP_ADD, 4'd15, 16'hFFFF);
        send_beat(maa_pkg::OP_READ, 4'd0, 16'h0000);
        settle();

        // A channel count of zero behaves as a single channel.
        set_config(maa_pkg::NCH_BITS'(0), 1'b0);
        send_beat(maa_pkg::OP_ADD, 4'd0, 16'h1234);
        send_beat(maa_pkg::OP_ADD, 4'd1, 16'h4321);
        send_beat(maa_pkg::OP_ADD, 4'd0, 16'h0002);
        send_beat(maa_pkg::OP_READ, 4'd5, 16'h00FF);
        settle();

        // Oversized count clamps; then the count shrinks with sums still held.
        set_config(maa_pkg::NCH_BITS'(31), 1'b1);
        send_beat(maa_pkg::OP_ADD, 4'd15, 16'h8000);
        send_beat(maa_pkg::OP_ADD, 4'd15, 16'h7FFF);
        send_beat(maa_pkg::OP_ADD, 4'd0, 16'hAAAA);
        send_beat(maa_pkg::OP_ADD, 4'd7, 16'h5555);
        settle();
        set_config(maa_pkg::NCH_BITS'(4), 1'b0);
        send_beat(maa_pkg::OP_ADD, 4'd3, 16'h0F0F);
        send_beat(maa_pkg::OP_READ, 4'hA, 16'h5A5A);
        settle();

        // Random phases: mostly well-formed sweeps, with stray and broken ones mixed in.
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       nch_raw = 0;
                1:       nch_raw = 1;
                2:       nch_raw = maa_pkg::ADDR_LIMIT;
                3:       nch_raw = $urandom_range(17, 31);
                default: nch_raw = $urandom_range(2, 15);
            endcase
            trk = 1'($urandom_range(0, 1));
            set_config(maa_pkg::NCH_BITS'(nch_raw), trk);
            n = sweep_len(nch_raw);
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            reads = $urandom_range(1, 3);
            repeat (reads)
            begin
                sweeps = (n > 8) ? $urandom_range(0, 2) : $urandom_range(0, 4);
                repeat (sweeps)
                begin
                    broken = 1'b0;
                    for (int c = 0; c < n && !broken; c++)
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            ch = maa_pkg::CH_BITS'($urandom);
                            send_beat(maa_pkg::OP_ADD, ch, pick_sample());
                            if (ch < n)
                            begin
                                random_items++;
                            end
                        end
                        if ($urandom_range(0, 29) == 0)
                        begin
                            broken = 1'b1;
                        end
                        else
                        begin
                            send_beat(maa_pkg::OP_ADD, maa_pkg::CH_BITS'(c), pick_sample());
                            random_items++;
                        end
                    end
                end
                send_beat(maa_pkg::OP_READ, maa_pkg::CH_BITS'($urandom),
                          maa_pkg::SAMPLE_BITS'($urandom));
                random_items++;
                // An immediate second read-out finds nothing accumulated.
                if ($urandom_range(0, 5) == 0)
                begin
                    send_beat(maa_pkg::OP_READ, maa_pkg::CH_BITS'($urandom),
                              maa_pkg::SAMPLE_BITS'($urandom));
                    random_items++;
                end
            end
            // Sometimes leave sums behind for the next register setting.
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    ch = maa_pkg::CH_BITS'($urandom_range(0, n - 1));
                    send_beat(maa_pkg::OP_ADD, ch, pick_sample());
                    random_items++;
                end
            end
            settle();
        end

        src_calm  = 1'b0;
        sink_calm = 1'b0;
        send_beat(maa_pkg::OP_READ, 4'd0, 16'h0000);
        settle();

        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
